### hdl/clis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clis_pkg
// Shared sizes, element type and saturating count add for the longest
// increasing subsequence counter.
// ----------------------------------------------------------------------------
package clis_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 32;

    // stored element width: at most 32 bits; values keep their low STORE_BITS bits
    localparam int STORE_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int ADDR_BITS  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int LEN_BITS   = CNT_BITS;

    localparam int QDEPTH     = 4;
    localparam int QADDR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [STORE_BITS-1:0] value;
        logic                         last;
    } t_elem;

    typedef struct packed {
        logic                  sat;
        logic [COUNT_BITS-1:0] sum;
    } t_sum;

    function automatic t_sum sat_add(input logic [COUNT_BITS-1:0] a,
                                     input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        t_sum                r;
        s = {1'b0, a} + {1'b0, b};
        if (s[COUNT_BITS]) begin
            r.sat = 1'b1;
            r.sum = '1;
        end else begin
            r.sat = 1'b0;
            r.sum = s[COUNT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/count_longest_increasing_subseq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_longest_increasing_subseq
// Counts the longest strictly increasing subsequences of a loaded sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one signed element per
//   transaction; i_last marks the final element and starts the computation.
//   Output channel (o_valid / i_ready) carries one result per sequence:
//   o_lis_length, o_lis_count (saturated) and o_overflow.
//   Elements load at one per cycle through a four-entry queue while it has
//   room; the sequencer drains it only in its load state. After the last
//   element the sequencer scans each position i against all later positions,
//   one pair per cycle through the value/length/count RAM read ports, then sums
//   the counts at the best length and registers the total for output.
//   Elements beyond the store depth are dropped and raise o_overflow.
//   Reset empties the queue, clears the element count and drops any result.
//   The stores need no clearing: every entry read was written in the same
//   sequence. While the receiver stalls the result holds in the output
//   register; the next sequence loads meanwhile and its result waits for it.
// ----------------------------------------------------------------------------
module count_longest_increasing_subseq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_lis_count,
    output logic [10:0]        o_lis_length,
    output logic               o_overflow
);

    logic            q_valid;
    logic            q_pop;
    clis_pkg::t_elem q_elem;

    // front: accept and queue elements
    clis_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .i_last    (i_last),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_elem  (q_elem)
    );

    // back: store, scan, sum and hold the result
    clis_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_elem     (q_elem),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_lis_count  (o_lis_count),
        .o_lis_length (o_lis_length),
        .o_overflow   (o_overflow)
    );

endmodule

### hdl/clis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clis_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module clis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/clis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clis_front
// Input side: accepts elements, narrows them to the stored width and holds
// them in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module clis_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [31:0]     i_value,
    input  logic                   i_last,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output clis_pkg::t_elem        o_q_elem
);

    clis_pkg::t_elem                  r_q [clis_pkg::QDEPTH];
    logic [clis_pkg::QADDR_BITS-1:0]  r_wptr;
    logic [clis_pkg::QADDR_BITS-1:0]  r_rptr;
    logic [clis_pkg::QCNT_BITS-1:0]   r_cnt;
    logic                             push;
    logic                             pop;
    clis_pkg::t_elem                  elem;

    assign o_ready   = (r_cnt != clis_pkg::QCNT_BITS'(clis_pkg::QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_elem  = r_q[r_rptr];

    // comparing the low bits as signed matches comparing the extended value
    assign elem.value = i_value[clis_pkg::STORE_BITS-1:0];
    assign elem.last  = i_last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hdl/clis_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clis_back
// Sequencer: stores elements, runs the backward pairwise scan and the final
// count sum, and holds the result in an output register.
// ----------------------------------------------------------------------------
module clis_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  clis_pkg::t_elem       i_q_elem,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [31:0]           o_lis_count,
    output logic [10:0]           o_lis_length,
    output logic                  o_overflow
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ROWA  = 3'd1;
    localparam logic [2:0] S_ROWB  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam int SW = clis_pkg::STORE_BITS;
    localparam int AW = clis_pkg::ADDR_BITS;
    localparam int NW = clis_pkg::CNT_BITS;
    localparam int LW = clis_pkg::LEN_BITS;
    localparam int CW = clis_pkg::COUNT_BITS;

    logic [2:0]           r_state;
    logic [NW-1:0]        r_n;
    logic [AW-1:0]        r_i;
    logic [NW-1:0]        r_j;
    logic                 r_dv;
    logic signed [SW-1:0] r_vi;
    logic [LW-1:0]        r_ilen;
    logic [CW-1:0]        r_icnt;
    logic [LW-1:0]        r_best;
    logic [CW-1:0]        r_total;
    logic                 r_sat;
    logic                 r_o_valid;
    logic [CW-1:0]        r_o_count;
    logic [LW-1:0]        r_o_len;
    logic                 r_o_ovf;

    logic [LW-1:0]        n_ilen;
    logic [CW-1:0]        n_icnt;
    logic [CW-1:0]        n_total;
    logic                 n_sat_scan;
    logic                 n_sat_sum;

    logic                 pop;
    logic                 fits;
    logic                 issue_more;
    logic                 pass_done;
    logic                 emit;
    logic [NW-1:0]        n_after;

    logic                 v_we;
    logic [AW-1:0]        v_raddr;
    logic [SW-1:0]        v_rdata;
    logic                 lc_we;
    logic [AW-1:0]        lc_raddr;
    logic [LW-1:0]        l_rdata;
    logic [CW-1:0]        c_rdata;
    logic [LW-1:0]        cand;
    clis_pkg::t_sum       scan_add;
    clis_pkg::t_sum       sum_add;

    assign o_q_pop    = (r_state == S_LOAD);
    assign pop        = o_q_pop && i_q_valid;
    assign fits       = (r_n < NW'(clis_pkg::MAX_ITEMS));
    assign n_after    = fits ? (r_n + NW'(1)) : r_n;
    assign issue_more = (r_j < r_n);
    assign pass_done  = !issue_more && !r_dv;
    assign emit       = (r_state == S_OUT) && (!r_o_valid || i_ready);

    assign v_we     = pop && fits;
    assign v_raddr  = (r_state == S_ROWA) ? r_i : AW'(r_j);
    assign lc_we    = (r_state == S_WRITE);
    assign lc_raddr = AW'(r_j);

    clis_ram #(.WIDTH(SW), .DEPTH(clis_pkg::MAX_ITEMS)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (AW'(r_n)),
        .i_wdata (i_q_elem.value),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    clis_ram #(.WIDTH(LW), .DEPTH(clis_pkg::MAX_ITEMS)) u_length_ram (
        .i_clk   (i_clk),
        .i_we    (lc_we),
        .i_waddr (r_i),
        .i_wdata (r_ilen),
        .i_raddr (lc_raddr),
        .o_rdata (l_rdata)
    );

    clis_ram #(.WIDTH(CW), .DEPTH(clis_pkg::MAX_ITEMS)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (lc_we),
        .i_waddr (r_i),
        .i_wdata (r_icnt),
        .i_raddr (lc_raddr),
        .o_rdata (c_rdata)
    );

    assign cand     = l_rdata + LW'(1);
    assign scan_add = clis_pkg::sat_add(r_icnt, c_rdata);
    assign sum_add  = clis_pkg::sat_add(r_total, c_rdata);

    // one pair per cycle: extend or restart the best run from position i
    always_comb begin
        n_ilen     = r_ilen;
        n_icnt     = r_icnt;
        n_sat_scan = 1'b0;
        if (r_dv && (r_vi < $signed(v_rdata))) begin
            if (cand > r_ilen) begin
                n_ilen = cand;
                n_icnt = c_rdata;
            end else if (cand == r_ilen) begin
                n_icnt     = scan_add.sum;
                n_sat_scan = scan_add.sat;
            end
        end
    end

    always_comb begin
        n_total   = r_total;
        n_sat_sum = 1'b0;
        if (r_dv && (l_rdata == r_best)) begin
            n_total   = sum_add.sum;
            n_sat_sum = sum_add.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_n       <= '0;
            r_sat     <= 1'b0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (pop) begin
                        r_n <= n_after;
                        if (!fits) begin
                            r_sat <= 1'b1;
                        end
                        if (i_q_elem.last) begin
                            r_i     <= AW'(n_after - NW'(1));
                            r_best  <= '0;
                            r_state <= S_ROWA;
                        end
                    end
                end
                S_ROWA: begin
                    r_state <= S_ROWB;
                end
                S_ROWB: begin
                    r_vi    <= $signed(v_rdata);
                    r_ilen  <= LW'(1);
                    r_icnt  <= CW'(1);
                    r_j     <= NW'(r_i) + NW'(1);
                    r_dv    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_ilen <= n_ilen;
                    r_icnt <= n_icnt;
                    if (n_sat_scan) begin
                        r_sat <= 1'b1;
                    end
                    r_dv <= issue_more;
                    if (issue_more) begin
                        r_j <= r_j + NW'(1);
                    end
                    if (pass_done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_ilen > r_best) begin
                        r_best <= r_ilen;
                    end
                    if (r_i == '0) begin
                        r_j     <= '0;
                        r_dv    <= 1'b0;
                        r_total <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_i     <= r_i - AW'(1);
                        r_state <= S_ROWA;
                    end
                end
                S_SUM: begin
                    r_total <= n_total;
                    if (n_sat_sum) begin
                        r_sat <= 1'b1;
                    end
                    r_dv <= issue_more;
                    if (issue_more) begin
                        r_j <= r_j + NW'(1);
                    end
                    if (pass_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (emit) begin
                        r_n     <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_count <= r_total;
            r_o_len   <= r_best;
            r_o_ovf   <= r_sat;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_lis_count  = 32'(r_o_count);
    assign o_lis_length = 11'(r_o_len);
    assign o_overflow   = r_o_ovf;

endmodule

### hdl/clis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clis_checker
// Port-level checks on both channels of the subsequence counter.
// ----------------------------------------------------------------------------
module clis_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic signed [31:0] i_value,
    input logic               i_last,
    input logic               o_valid,
    input logic               i_ready,
    input logic [31:0]        o_lis_count,
    input logic [10:0]        o_lis_length,
    input logic               o_overflow
);

    // hold a stalled element and its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_value) && $stable(i_last))
        else $error("stalled element changed");

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_lis_count)
            && $stable(o_lis_length) && $stable(o_overflow))
        else $error("stalled result changed");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result present after reset");

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_lis_length != 11'd0)
        else $error("zero subsequence length");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_lis_length <= 11'(clis_pkg::MAX_ITEMS))
        else $error("length beyond store depth");

endmodule

bind count_longest_increasing_subseq clis_checker u_clis_checker (.*);
